// File: src/h3w_pkg.sv
// ----------------------------------------------------------------------------
// h3w_pkg
// Shared types, constants and orientation tables of the 3D Hilbert walker.
// ----------------------------------------------------------------------------
package h3w_pkg;

    localparam int MAX_DEPTH = 10;
    localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
    localparam int DEP_W     = (LVL_W > 4) ? LVL_W : 4;
    localparam int CNT_W     = 3 * MAX_DEPTH + 1;
    localparam int IDX_W     = 30;
    localparam int CFG_IDX_W = 1;

    localparam logic [2:0] MV_NONE = 3'd6;
    localparam logic [3:0] NUM_ORIENT = 4'd12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH  = 1'b0,
        REG_ORIENT = 1'b1
    } t_cfg_reg;

    // Per-cell control from the walker.
    typedef struct packed {
        logic set_top;   // load the start orientation, child 0
        logic incr;      // step the child index by one
        logic en;        // level lies inside the current depth
    } t_cell_ctl;

    localparam logic [3:0] SUB_ORIENT [16][8] = '{
        '{4'd2,  4'd4,  4'd4,  4'd7,  4'd7,  4'd10, 4'd10, 4'd3},
        '{4'd3,  4'd5,  4'd5,  4'd6,  4'd6,  4'd11, 4'd11, 4'd2},
        '{4'd4,  4'd0,  4'd0,  4'd8,  4'd8,  4'd1,  4'd1,  4'd11},
        '{4'd5,  4'd1,  4'd1,  4'd9,  4'd9,  4'd0,  4'd0,  4'd10},
        '{4'd0,  4'd2,  4'd2,  4'd5,  4'd5,  4'd9,  4'd9,  4'd6},
        '{4'd1,  4'd3,  4'd3,  4'd4,  4'd4,  4'd8,  4'd8,  4'd7},
        '{4'd8,  4'd10, 4'd10, 4'd1,  4'd1,  4'd4,  4'd4,  4'd9},
        '{4'd9,  4'd11, 4'd11, 4'd0,  4'd0,  4'd5,  4'd5,  4'd8},
        '{4'd10, 4'd6,  4'd6,  4'd2,  4'd2,  4'd7,  4'd7,  4'd5},
        '{4'd11, 4'd7,  4'd7,  4'd3,  4'd3,  4'd6,  4'd6,  4'd4},
        '{4'd6,  4'd8,  4'd8,  4'd11, 4'd11, 4'd3,  4'd3,  4'd0},
        '{4'd7,  4'd9,  4'd9,  4'd10, 4'd10, 4'd2,  4'd2,  4'd1},
        '{4'd2,  4'd4,  4'd4,  4'd7,  4'd7,  4'd10, 4'd10, 4'd3},
        '{4'd2,  4'd4,  4'd4,  4'd7,  4'd7,  4'd10, 4'd10, 4'd3},
        '{4'd2,  4'd4,  4'd4,  4'd7,  4'd7,  4'd10, 4'd10, 4'd3},
        '{4'd2,  4'd4,  4'd4,  4'd7,  4'd7,  4'd10, 4'd10, 4'd3}
    };

    localparam logic [2:0] STEP_DIR [16][7] = '{
        '{3'd4, 3'd0, 3'd5, 3'd2, 3'd4, 3'd1, 3'd5},
        '{3'd5, 3'd0, 3'd4, 3'd3, 3'd5, 3'd1, 3'd4},
        '{3'd0, 3'd2, 3'd1, 3'd4, 3'd0, 3'd3, 3'd1},
        '{3'd0, 3'd3, 3'd1, 3'd5, 3'd0, 3'd2, 3'd1},
        '{3'd2, 3'd4, 3'd3, 3'd0, 3'd2, 3'd5, 3'd3},
        '{3'd3, 3'd5, 3'd2, 3'd0, 3'd3, 3'd4, 3'd2},
        '{3'd4, 3'd1, 3'd5, 3'd3, 3'd4, 3'd0, 3'd5},
        '{3'd5, 3'd1, 3'd4, 3'd2, 3'd5, 3'd0, 3'd4},
        '{3'd1, 3'd3, 3'd0, 3'd4, 3'd1, 3'd2, 3'd0},
        '{3'd1, 3'd2, 3'd0, 3'd5, 3'd1, 3'd3, 3'd0},
        '{3'd3, 3'd4, 3'd2, 3'd1, 3'd3, 3'd5, 3'd2},
        '{3'd2, 3'd5, 3'd3, 3'd1, 3'd2, 3'd4, 3'd3},
        '{3'd4, 3'd0, 3'd5, 3'd2, 3'd4, 3'd1, 3'd5},
        '{3'd4, 3'd0, 3'd5, 3'd2, 3'd4, 3'd1, 3'd5},
        '{3'd4, 3'd0, 3'd5, 3'd2, 3'd4, 3'd1, 3'd5},
        '{3'd4, 3'd0, 3'd5, 3'd2, 3'd4, 3'd1, 3'd5}
    };

    function automatic logic [3:0] clean_orient(input logic [3:0] o);
        return (o < NUM_ORIENT) ? o : 4'd0;
    endfunction

endpackage

// File: src/h3w_cell.sv
// ----------------------------------------------------------------------------
// h3w_cell
// One level of the walk stack: orientation and child index of that level.
// ----------------------------------------------------------------------------
module h3w_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  h3w_pkg::t_cell_ctl  i_ctl,
    input  logic [3:0]          i_start_orient,
    input  logic                i_seed,
    input  logic [3:0]          i_par_orient,
    input  logic [2:0]          i_par_child,
    output logic [3:0]          o_orient,
    output logic [2:0]          o_child,
    output logic                o_seed
);

    logic [3:0] r_orient, n_orient;
    logic [2:0] r_child,  n_child;
    logic       r_seed,   n_seed;

    always_comb begin
        n_orient = r_orient;
        n_child  = r_child;
        n_seed   = 1'b0;
        if (i_ctl.set_top) begin
            n_orient = h3w_pkg::clean_orient(i_start_orient);
            n_child  = 3'd0;
            n_seed   = 1'b1;
        end else if (i_ctl.incr) begin
            n_child = r_child + 3'd1;
            n_seed  = 1'b1;
        end else if (i_seed && i_ctl.en) begin
            // The parent was updated last cycle; its new state picks this level.
            n_orient = h3w_pkg::clean_orient(h3w_pkg::SUB_ORIENT[i_par_orient][i_par_child]);
            n_child  = 3'd0;
            n_seed   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient <= 4'd0;
            r_child  <= 3'd0;
            r_seed   <= 1'b0;
        end else begin
            r_orient <= n_orient;
            r_child  <= n_child;
            r_seed   <= n_seed;
        end
    end

    assign o_orient = r_orient;
    assign o_child  = r_child;
    assign o_seed   = r_seed;

endmodule

// File: src/hilbert3d_curve_walker_top.sv
// ----------------------------------------------------------------------------
// hilbert3d_curve_walker_top
// Steps along a 3D Hilbert curve, one cell per request.
// ----------------------------------------------------------------------------
// Usage: configuration writes (index 0 curve_depth, 1 start_orientation) go
// over i_cfg_valid/o_cfg_ready, always ready; the user must write only while
// the walker is idle, the block does not enforce it. Each input request
// (i_valid/o_ready) carries i_restart: 1 starts a new walk, 0 advances one
// cell. Each request yields one result on o_valid/i_ready: move direction,
// cell index, last-cell and overrun flags. The result is registered and
// appears in the cycle after the request is taken. The stack is a row of
// level cells; after a child step or restart at level k a re-seed wave
// walks down one level per cycle to the last used level. The next request
// is taken once that wave ends; a step at the deepest used level starts no
// wave. A stalled result holds o_valid and blocks new requests until it
// is taken. Reset gives the first cell of a depth-1 walk in orientation 0,
// depth 1, start orientation 0, and no result pending.
// ----------------------------------------------------------------------------
module hilbert3d_curve_walker_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_restart,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [2:0]                         o_move_dir,
    output logic [h3w_pkg::IDX_W-1:0]          o_cell_index,
    output logic                               o_last_cell,
    output logic                               o_overrun,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [h3w_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [3:0]                         i_cfg_data
);

    localparam int MD = h3w_pkg::MAX_DEPTH;

    logic [3:0] r_depth, r_start;
    logic [h3w_pkg::CNT_W-1:0] r_count, n_count;
    logic r_done, n_done;
    logic r_ovalid;
    logic [2:0] r_move, n_move;
    logic [h3w_pkg::IDX_W-1:0] r_idx;
    logic r_last, r_over, n_over;

    logic [3:0] lv_orient [MD];
    logic [2:0] lv_child  [MD];
    logic       lv_seed   [MD];
    h3w_pkg::t_cell_ctl ctl [MD];
    logic [MD-1:0] incr_vec;

    logic [h3w_pkg::DEP_W-1:0] d_eff;
    logic [h3w_pkg::CNT_W-1:0] end_idx;
    logic wave, accept, found;
    logic [h3w_pkg::LVL_W-1:0] k_sel;

    assign d_eff = (h3w_pkg::DEP_W'(r_depth) > h3w_pkg::DEP_W'(MD))
                 ? h3w_pkg::DEP_W'(MD) : h3w_pkg::DEP_W'(r_depth);
    assign end_idx = (h3w_pkg::CNT_W'(1) << (3 * d_eff)) - h3w_pkg::CNT_W'(1);

    // The wave is alive while a seeded level still has a used level below it.
    always_comb begin
        wave = 1'b0;
        for (int j = 0; j < MD - 1; j++) begin
            if (lv_seed[j] && (h3w_pkg::DEP_W'(j + 1) < d_eff)) wave = 1'b1;
        end
    end

    assign o_ready     = !wave && (!r_ovalid || i_ready);
    assign accept      = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    // Deepest used level whose child can still step; none once the walk has ended.
    always_comb begin
        found = 1'b0;
        k_sel = '0;
        for (int j = 0; j < MD; j++) begin
            if ((h3w_pkg::DEP_W'(j) < d_eff) && (lv_child[j] != 3'd7)) begin
                found = 1'b1;
                k_sel = h3w_pkg::LVL_W'(j);
            end
        end
        if (r_done || (r_count >= end_idx)) found = 1'b0;
    end

    always_comb begin
        n_count = r_count;
        n_move  = h3w_pkg::MV_NONE;
        n_over  = 1'b0;
        incr_vec = '0;
        if (i_restart) begin
            n_count = '0;
        end else if (found) begin
            n_move  = h3w_pkg::STEP_DIR[lv_orient[k_sel]][lv_child[k_sel]];
            n_count = r_count + h3w_pkg::CNT_W'(1);
            incr_vec[k_sel] = accept;
        end else begin
            n_over = 1'b1;
        end
        n_done = n_over || (n_count >= end_idx);
    end

    for (genvar g = 0; g < MD; g++) begin : g_lvl
        assign ctl[g].set_top = (g == 0) && accept && i_restart && (d_eff != '0);
        assign ctl[g].incr    = incr_vec[g];
        assign ctl[g].en      = h3w_pkg::DEP_W'(g) < d_eff;
        if (g == 0) begin : g_top
            h3w_cell u_cell (
                .i_clk, .i_rst_n, .i_ctl(ctl[g]), .i_start_orient(r_start),
                .i_seed(1'b0), .i_par_orient(4'd0), .i_par_child(3'd0),
                .o_orient(lv_orient[g]), .o_child(lv_child[g]), .o_seed(lv_seed[g])
            );
        end else begin : g_sub
            h3w_cell u_cell (
                .i_clk, .i_rst_n, .i_ctl(ctl[g]), .i_start_orient(r_start),
                .i_seed(lv_seed[g-1]), .i_par_orient(lv_orient[g-1]),
                .i_par_child(lv_child[g-1]),
                .o_orient(lv_orient[g]), .o_child(lv_child[g]), .o_seed(lv_seed[g])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= 4'd1;
            r_start  <= 4'd0;
            r_count  <= '0;
            r_done   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    h3w_pkg::REG_DEPTH:  r_depth <= i_cfg_data;
                    h3w_pkg::REG_ORIENT: r_start <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_count  <= n_count;
                r_done   <= n_done;
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_move <= n_move;
            r_idx  <= n_count[h3w_pkg::IDX_W-1:0];
            r_last <= n_done;
            r_over <= n_over;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_move_dir   = r_move;
    assign o_cell_index = r_idx;
    assign o_last_cell  = r_last;
    assign o_overrun    = r_over;

    a_incr_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(incr_vec)) else $error("more than one level stepped");
    a_over_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_over) |-> (r_last && r_move == h3w_pkg::MV_NONE))
        else $error("overrun without hold flags");
    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_restart && found) |=> (r_count == $past(r_count) + 1'b1))
        else $error("cell count did not step");
    a_no_accept_in_wave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wave |-> !accept) else $error("request taken during re-seed");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3D Hilbert walker. It keeps its own stack model
// of the walk, drives restart/advance requests with random gaps and receiver
// stalls, and checks each result against the predicted move and cell.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [2:0]                mv;
        logic [h3w_pkg::IDX_W-1:0] idx;
        logic                      last;
        logic                      over;
    } t_cell_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_restart = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [2:0] o_move_dir;
    logic [h3w_pkg::IDX_W-1:0] o_cell_index;
    logic o_last_cell;
    logic o_overrun;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [h3w_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [3:0] i_cfg_data = '0;

    hilbert3d_curve_walker_top dut (.*);

    always #5 i_clk = ~i_clk;

    // Walk model: per-level orientation and child, count and end flag.
    logic [3:0] m_depth, m_start;
    logic [3:0] m_orient [h3w_pkg::MAX_DEPTH];
    logic [2:0] m_child [h3w_pkg::MAX_DEPTH];
    logic [63:0] m_count;
    logic m_done;

    bit pend_q[$];
    t_cell_res cell_q[$];
    int n_err = 0;
    int n_items = 0;
    int cycles = 0;
    bit calm = 1'b0;
    int stall_req = 0;
    int stall_seen = 0;
    int stall_cnt = 0;

    function automatic logic [3:0] fix_orient(input logic [3:0] o);
        return (o < 4'd12) ? o : 4'd0;
    endfunction

    task automatic reseed(input int from, input int d);
        for (int j = from; j < d; j++) begin
            if (j != 0) begin
                m_orient[j] = fix_orient(h3w_pkg::SUB_ORIENT[m_orient[j-1]][m_child[j-1]]);
                m_child[j]  = 3'd0;
            end
        end
    endtask

    task automatic walk_step(input bit rs);
        int d, k;
        logic [63:0] last_idx;
        t_cell_res r;
        bit found;
        d = (m_depth > h3w_pkg::MAX_DEPTH) ? h3w_pkg::MAX_DEPTH : int'(m_depth);
        last_idx = (64'd1 << (3 * d)) - 64'd1;
        r.mv = h3w_pkg::MV_NONE;
        r.over = 1'b0;
        found = 1'b0;
        k = d;
        if (rs) begin
            if (d > 0) begin
                m_orient[0] = fix_orient(m_start);
                m_child[0] = 3'd0;
                reseed(1, d);
            end
            m_count = '0;
        end else begin
            if (!m_done && m_count < last_idx) begin
                while (k > 0 && !found) begin
                    k--;
                    if (m_child[k] < 3'd7) found = 1'b1;
                end
            end
            if (found) begin
                r.mv = h3w_pkg::STEP_DIR[m_orient[k]][m_child[k]];
                m_child[k] = m_child[k] + 3'd1;
                reseed(k + 1, d);
                m_count++;
            end else begin
                r.over = 1'b1;
            end
        end
        m_done = r.over || m_count >= last_idx;
        r.idx = m_count[h3w_pkg::IDX_W-1:0];
        r.last = m_done;
        cell_q.push_back(r);
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) walk_step(i_restart);
            if (!i_valid || o_ready) begin
                if (pend_q.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
                    i_valid <= 1'b1;
                    i_restart <= pend_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge i_clk) begin
        t_cell_res e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL hilbert3d_curve_walker_top");
            $finish;
        end else if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (cell_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected result idx=%0d", o_cell_index);
                end else begin
                    e = cell_q.pop_front();
                    if (o_move_dir !== e.mv || o_cell_index !== e.idx ||
                        o_last_cell !== e.last || o_overrun !== e.over) begin
                        n_err++;
                        if (n_err <= 10)
                            $display({"mismatch exp mv=%0d idx=%0d last=%0b over=%0b",
                                      " got mv=%0d idx=%0d last=%0b over=%0b"},
                                e.mv, e.idx, e.last, e.over,
                                o_move_dir, o_cell_index, o_last_cell, o_overrun);
                    end
                end
            end
            if (stall_req != stall_seen) begin
                stall_seen <= stall_req;
                stall_cnt <= 300;
                i_ready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt <= stall_cnt - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= calm || $urandom_range(99) >= 32;
            end
        end
    end

    task automatic settle();
        while (pend_q.size() > 0 || i_valid || cell_q.size() > 0) @(posedge i_clk);
        repeat (h3w_pkg::MAX_DEPTH + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(input h3w_pkg::t_cfg_reg idx, input logic [3:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == h3w_pkg::REG_DEPTH) m_depth = val;
        else m_start = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_walk(input bit rs, input int n, input int noise);
        if (rs) pend_q.push_back(1'b1);
        for (int i = 0; i < n; i++)
            pend_q.push_back(noise > 0 && $urandom_range(99) < noise);
        n_items += n + rs;
    endtask

    initial begin
        int d, n, ph;
        m_depth = 4'd1;
        m_start = 4'd0;
        for (int j = 0; j < h3w_pkg::MAX_DEPTH; j++) begin
            m_orient[j] = '0;
            m_child[j] = '0;
        end
        m_count = '0;
        m_done = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset state is a walk that can be advanced right away, up to overrun.
        add_walk(1'b0, 9, 0);
        settle();
        // Depth zero: a single cell, so every advance overruns.
        write_reg(h3w_pkg::REG_DEPTH, 4'd0);
        add_walk(1'b1, 2, 0);
        settle();
        // Unused orientation codes fall back to the first one.
        write_reg(h3w_pkg::REG_DEPTH, 4'd1);
        write_reg(h3w_pkg::REG_ORIENT, 4'd15);
        add_walk(1'b1, 3, 0);
        settle();
        write_reg(h3w_pkg::REG_ORIENT, 4'd11);
        add_walk(1'b1, 8, 0);
        settle();

        ph = 0;
        while (n_items < 950) begin
            ph++;
            calm = (ph == 3);
            d = ($urandom_range(9) < 7) ? $urandom_range(3) : $urandom_range(15);
            if ($urandom_range(5) != 0) write_reg(h3w_pkg::REG_DEPTH, d[3:0]);
            if ($urandom_range(3) != 0)
                write_reg(h3w_pkg::REG_ORIENT, 4'($urandom_range(15)));
            n = (d <= 2) ? (1 << (3 * d)) + 2 : $urandom_range(60, 150);
            // A phase without a restart continues the old stack under new settings.
            add_walk($urandom_range(7) != 0, n, (ph % 4 == 1) ? 5 : 0);
            if (ph == 2) stall_req++;
            settle();
        end
        calm = 1'b0;

        if (n_err == 0) $display("PASS hilbert3d_curve_walker_top");
        else $display("FAIL hilbert3d_curve_walker_top");
        $finish;
    end
endmodule
